// File: hw/rtl/dcl_pkg.sv
// Shared types and constants for the displacement-control load factor block.
// No dependencies; imported by dcl_div, the top level and the testbench.
package dcl_pkg;

    localparam int VALUE_WIDTH_DEF   = 48;
    localparam int MAX_EQUATIONS_DEF = 4096;
    localparam int FRAC_BITS         = 24;
    localparam int MUL_DIGIT         = 16;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int CTRL_EQ_WIDTH     = 12;
    localparam int EQ_COUNT_WIDTH    = 13;
    localparam int EQ_EQUATIONS_RST  = 4096;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_VARIABLE_MODE,
        CFG_EQUATIONS_IN_USE,
        CFG_INIT_CTRL_EQ,
        CFG_INIT_CTRL_FACTOR
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DECIDE,
        ST_RATIO_GO,
        ST_RATIO_WAIT,
        ST_MUL,
        ST_MUL_END,
        ST_LAM_GO,
        ST_LAM_WAIT
    } state_t;

    typedef struct packed {
        logic done;
        logic fault;
    } div_status_t;

endpackage

// File: hw/rtl/dcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/dcl_div.sv
// Bit-serial signed Q-format divider, one quotient bit per cycle, saturating.
// Depends on dcl_pkg (FRAC_BITS, div_status_t).
module dcl_div
    import dcl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic [VALUE_WIDTH-1:0] quotient,
    output div_status_t            status
);

    localparam int W    = VALUE_WIDTH;
    localparam int QW   = W + FRAC_BITS;
    localparam int CNTW = $clog2(QW + 1);
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            fault_reg, fault_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]   num_reg, num_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [W-1:0]    den_reg, den_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic            neg_reg, neg_next;
    logic [W-1:0]    q_out_reg, q_out_next;
    logic [W:0]      trial;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] clamp(input logic neg, input logic [QW-1:0] m);
        logic [QW-1:0] lim;
        lim = QW'(NEG_MIN);
        if (neg)
        begin
            clamp = (m > lim) ? NEG_MIN : (~m[W-1:0] + 1'b1);
        end
        else
        begin
            clamp = (m > QW'(POS_MAX)) ? POS_MAX : m[W-1:0];
        end
    endfunction

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        fault_next = fault_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        q_out_next = q_out_reg;
        trial      = {rem_reg, num_reg[QW-1]};
        if (start)
        begin
            neg_next = dividend[W-1] ^ divisor[W-1];
            if (divisor == '0)
            begin
                done_next  = 1'b1;
                fault_next = 1'b1;
                q_out_next = dividend[W-1] ? NEG_MIN : POS_MAX;
            end
            else
            begin
                fault_next = 1'b0;
                busy_next  = 1'b1;
                num_next   = {mag(dividend), {FRAC_BITS{1'b0}}};
                den_next   = mag(divisor);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = CNTW'(QW);
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            num_next = {num_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                q_out_next = clamp(neg_reg, quo_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            fault_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            fault_reg <= fault_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        q_out_reg <= q_out_next;
    end

    assign quotient     = q_out_reg;
    assign status.done  = done_reg;
    assign status.fault = fault_reg;

endmodule

// File: hw/rtl/displacement_control_load_factor.sv
// Top level of the displacement-control load factor block.
// Depends on dcl_pkg, dcl_ram and dcl_div.
//
// After reset the block sweeps its per-equation RAM to zero, one entry a cycle, with busy
// high. Each equation word is then read from the RAM when accepted in idle; in the update
// state its path length and previous displacement are written back when tracking. After the
// update state of the last word of a call come a decide state and the load factor divide on
// the shared bit-serial divider; done rises in the cycle after the one that sees the divide
// finish. A control equation switch adds one more divide plus a digit-serial multiply of the
// control factor by the ratio. The result is shown for exactly one cycle on done and cannot
// be held off.
module displacement_control_load_factor
    import dcl_pkg::*;
#(
    parameter int MAX_EQUATIONS = MAX_EQUATIONS_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [VALUE_WIDTH-1:0]     total_disp,
    input  logic [VALUE_WIDTH-1:0]     tangent_incr,
    input  logic [VALUE_WIDTH-1:0]     residual_incr,
    input  logic                       first_iteration,
    input  logic                       first_step,
    input  logic                       last_equation,
    output logic                       done,
    output logic [VALUE_WIDTH-1:0]     load_factor,
    output logic [CTRL_EQ_WIDTH-1:0]   control_equation,
    output logic                       divide_fault,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]     cfg_data
);

    localparam int W    = VALUE_WIDTH;
    localparam int IW   = $clog2(MAX_EQUATIONS);
    localparam int CMPW = 18;
    localparam int YW   = ((W + MUL_DIGIT - 1) / MUL_DIGIT) * MUL_DIGIT;
    localparam int NDIG = YW / MUL_DIGIT;
    localparam int PW   = W + YW;
    localparam int SW   = PW - FRAC_BITS;
    localparam int MCW  = $clog2(NDIG + 1);
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    state_t                    state_reg, state_next;
    logic [IW-1:0]             clr_addr_reg, clr_addr_next;
    logic                      vmode_reg, vmode_next;
    logic [EQ_COUNT_WIDTH-1:0] eq_use_reg, eq_use_next;
    logic [CTRL_EQ_WIDTH-1:0]  ctrl_eq_reg, ctrl_eq_next;
    logic [W-1:0]              factor_reg, factor_next;
    logic [IW-1:0]             item_idx_reg, item_idx_next;
    logic [IW-1:0]             max_idx_reg, max_idx_next;
    logic [W-1:0]              max_abs_reg, max_abs_next;
    logic [W-1:0]              tan_ctrl_reg, tan_ctrl_next;
    logic [W-1:0]              res_ctrl_reg, res_ctrl_next;
    logic [W-1:0]              len_ctrl_reg, len_ctrl_next;
    logic [W-1:0]              tan_max_reg, tan_max_next;
    logic [W-1:0]              len_max_reg, len_max_next;
    logic                      done_reg, done_next;
    logic                      fault_acc_reg, fault_acc_next;
    logic [MCW-1:0]            mul_cnt_reg, mul_cnt_next;

    logic [W-1:0]  x_reg, x_next, t_reg, t_next, r_reg, r_next;
    logic          fi_reg, fi_next, fs_reg, fs_next, last_reg, last_next;
    logic          fin_fi_reg, fin_fi_next, fin_track_reg, fin_track_next;
    logic [YW-1:0] mul_y_reg, mul_y_next;
    logic [PW-1:0] mul_acc_reg, mul_acc_next;
    logic          mul_neg_reg, mul_neg_next;
    logic [W-1:0]  lf_reg, lf_next;
    logic          df_reg, df_next;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr;
    logic [2*W-1:0]   ram_wdata, ram_rdata;
    logic             div_start;
    logic [W-1:0]     div_a, div_b, div_q;
    div_status_t      div_st;

    logic [W-1:0]           prev_disp, path_old, path_new, len_cur, tmag, ratio, fmag;
    logic [W:0]             diff, dabs;
    logic [W+1:0]           psum;
    logic                   track, last_item, same_dir;
    logic [CMPW-1:0]        idx_plus, n_use;
    logic [W+MUL_DIGIT-1:0] pprod;
    logic [SW-1:0]          mul_s;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] qneg(input logic [W-1:0] v);
        qneg = (v == NEG_MIN) ? POS_MAX : (~v + 1'b1);
    endfunction

    dcl_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_EQUATIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item_idx_reg),
        .rdata (ram_rdata)
    );

    dcl_div #(
        .VALUE_WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .status   (div_st)
    );

    // per-equation datapath, valid in the update cycle
    assign prev_disp = ram_rdata[2*W-1:W];
    assign path_old  = ram_rdata[W-1:0];
    assign track     = fi_reg && !fs_reg && vmode_reg;
    assign diff      = {x_reg[W-1], x_reg} - {prev_disp[W-1], prev_disp};
    assign dabs      = diff[W] ? (~diff + 1'b1) : diff;
    assign psum      = {2'b00, path_old} + {1'b0, dabs};
    assign path_new  = (psum > (W+2)'(POS_MAX)) ? POS_MAX : psum[W-1:0];
    assign len_cur   = track ? path_new : path_old;
    assign tmag      = mag(t_reg);
    assign idx_plus  = CMPW'(item_idx_reg) + CMPW'(1);
    assign n_use     = (eq_use_reg == '0) ? CMPW'(1) : CMPW'(eq_use_reg);
    assign last_item = last_reg || (idx_plus >= n_use) || (idx_plus >= CMPW'(MAX_EQUATIONS));

    assign same_dir = (tan_max_reg != '0) && (tan_ctrl_reg != '0)
                      && (tan_max_reg[W-1] == tan_ctrl_reg[W-1]);
    assign ratio    = same_dir ? div_q : qneg(div_q);
    assign fmag     = mag(factor_reg);
    assign pprod    = (W+MUL_DIGIT)'(fmag) * (W+MUL_DIGIT)'(mul_y_reg[YW-1 -: MUL_DIGIT]);
    assign mul_s    = mul_acc_reg[PW-1:FRAC_BITS];

    assign div_a = (state_reg == ST_RATIO_GO) ? len_max_reg
                   : (fin_fi_reg ? factor_reg : qneg(res_ctrl_reg));
    assign div_b = (state_reg == ST_RATIO_GO) ? len_ctrl_reg : tan_ctrl_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        vmode_next     = vmode_reg;
        eq_use_next    = eq_use_reg;
        ctrl_eq_next   = ctrl_eq_reg;
        factor_next    = factor_reg;
        item_idx_next  = item_idx_reg;
        max_idx_next   = max_idx_reg;
        max_abs_next   = max_abs_reg;
        tan_ctrl_next  = tan_ctrl_reg;
        res_ctrl_next  = res_ctrl_reg;
        len_ctrl_next  = len_ctrl_reg;
        tan_max_next   = tan_max_reg;
        len_max_next   = len_max_reg;
        done_next      = 1'b0;
        fault_acc_next = fault_acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        fi_next        = fi_reg;
        fs_next        = fs_reg;
        last_next      = last_reg;
        fin_fi_next    = fin_fi_reg;
        fin_track_next = fin_track_reg;
        mul_y_next     = mul_y_reg;
        mul_acc_next   = mul_acc_reg;
        mul_neg_next   = mul_neg_reg;
        lf_next        = lf_reg;
        df_next        = df_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = item_idx_reg;
        ram_wdata      = {x_reg, path_new};
        div_start      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == IW'(MAX_EQUATIONS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ram_re     = 1'b1;
                    x_next     = total_disp;
                    t_next     = tangent_incr;
                    r_next     = residual_incr;
                    fi_next    = first_iteration;
                    fs_next    = first_step;
                    last_next  = last_equation;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we = track;
                if (item_idx_reg == '0 || tmag > max_abs_reg)
                begin
                    max_idx_next = item_idx_reg;
                    max_abs_next = tmag;
                    tan_max_next = t_reg;
                    len_max_next = len_cur;
                end
                if (CMPW'(item_idx_reg) == CMPW'(ctrl_eq_reg))
                begin
                    tan_ctrl_next = t_reg;
                    res_ctrl_next = r_reg;
                    len_ctrl_next = len_cur;
                end
                if (last_item)
                begin
                    fin_fi_next    = fi_reg;
                    fin_track_next = track;
                    item_idx_next  = '0;
                    state_next     = ST_DECIDE;
                end
                else
                begin
                    item_idx_next = idx_plus[IW-1:0];
                    state_next    = ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                if (fin_track_reg && (CMPW'(max_idx_reg) != CMPW'(ctrl_eq_reg)))
                begin
                    state_next = ST_RATIO_GO;
                end
                else
                begin
                    state_next = ST_LAM_GO;
                end
            end
            ST_RATIO_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT:
            begin
                if (div_st.done)
                begin
                    fault_acc_next = fault_acc_reg | div_st.fault;
                    mul_y_next     = YW'(mag(ratio));
                    mul_neg_next   = factor_reg[W-1] ^ ratio[W-1];
                    mul_acc_next   = '0;
                    mul_cnt_next   = MCW'(NDIG);
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // one 16-bit digit of the ratio per cycle, most significant first
                mul_acc_next = (mul_acc_reg << MUL_DIGIT) + PW'(pprod);
                mul_y_next   = mul_y_reg << MUL_DIGIT;
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == MCW'(1))
                begin
                    state_next = ST_MUL_END;
                end
            end
            ST_MUL_END:
            begin
                if (mul_neg_reg)
                begin
                    factor_next = (mul_s > SW'(NEG_MIN)) ? NEG_MIN : (~mul_s[W-1:0] + 1'b1);
                end
                else
                begin
                    factor_next = (mul_s > SW'(POS_MAX)) ? POS_MAX : mul_s[W-1:0];
                end
                ctrl_eq_next  = CTRL_EQ_WIDTH'(max_idx_reg);
                tan_ctrl_next = tan_max_reg;
                state_next    = ST_LAM_GO;
            end
            ST_LAM_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_LAM_WAIT;
            end
            ST_LAM_WAIT:
            begin
                if (div_st.done)
                begin
                    lf_next        = div_q;
                    df_next        = fault_acc_reg | div_st.fault;
                    done_next      = 1'b1;
                    fault_acc_next = 1'b0;
                    max_idx_next   = '0;
                    max_abs_next   = '0;
                    tan_ctrl_next  = '0;
                    res_ctrl_next  = '0;
                    len_ctrl_next  = '0;
                    tan_max_next   = '0;
                    len_max_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_VARIABLE_MODE:    vmode_next   = cfg_data[0];
                CFG_EQUATIONS_IN_USE: eq_use_next  = cfg_data[EQ_COUNT_WIDTH-1:0];
                CFG_INIT_CTRL_EQ:     ctrl_eq_next = cfg_data[CTRL_EQ_WIDTH-1:0];
                CFG_INIT_CTRL_FACTOR: factor_next  = cfg_data;
                default:              vmode_next   = vmode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            vmode_reg     <= 1'b0;
            eq_use_reg    <= EQ_COUNT_WIDTH'(EQ_EQUATIONS_RST);
            ctrl_eq_reg   <= '0;
            factor_reg    <= W'(64'd1 << FRAC_BITS);
            item_idx_reg  <= '0;
            max_idx_reg   <= '0;
            max_abs_reg   <= '0;
            tan_ctrl_reg  <= '0;
            res_ctrl_reg  <= '0;
            len_ctrl_reg  <= '0;
            tan_max_reg   <= '0;
            len_max_reg   <= '0;
            done_reg      <= 1'b0;
            fault_acc_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            vmode_reg     <= vmode_next;
            eq_use_reg    <= eq_use_next;
            ctrl_eq_reg   <= ctrl_eq_next;
            factor_reg    <= factor_next;
            item_idx_reg  <= item_idx_next;
            max_idx_reg   <= max_idx_next;
            max_abs_reg   <= max_abs_next;
            tan_ctrl_reg  <= tan_ctrl_next;
            res_ctrl_reg  <= res_ctrl_next;
            len_ctrl_reg  <= len_ctrl_next;
            tan_max_reg   <= tan_max_next;
            len_max_reg   <= len_max_next;
            done_reg      <= done_next;
            fault_acc_reg <= fault_acc_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        t_reg         <= t_next;
        r_reg         <= r_next;
        fi_reg        <= fi_next;
        fs_reg        <= fs_next;
        last_reg      <= last_next;
        fin_fi_reg    <= fin_fi_next;
        fin_track_reg <= fin_track_next;
        mul_y_reg     <= mul_y_next;
        mul_acc_reg   <= mul_acc_next;
        mul_neg_reg   <= mul_neg_next;
        lf_reg        <= lf_next;
        df_reg        <= df_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign load_factor      = lf_reg;
    assign control_equation = ctrl_eq_reg;
    assign divide_fault     = df_reg;

`ifndef NO_ASSERTIONS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == ST_UPDATE))
        else $error("accepted word did not enter the update cycle");

    a_done_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (item_idx_reg == '0 && max_abs_reg == '0 && !fault_acc_reg))
        else $error("call state not rewound with the result");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("RAM written while idle");
`endif

endmodule

// File: sim/tb_displacement_control_load_factor.sv
// Self-checking testbench for displacement_control_load_factor: directed and random calls,
// each checked against an in-bench predictor of the load factor. Depends on dcl_pkg and the RTL.
module tb_displacement_control_load_factor;
    import dcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW    = 48;
    localparam int NEQ   = 4096;
    localparam int DRAIN = 250;
    localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'hFFFF_8000_0000_0000;
    localparam logic [63:0] SIGN_BIT = 64'h0000_8000_0000_0000;
    localparam logic [63:0] ONE_Q = 64'd16777216;

    typedef struct {
        logic [VW-1:0] disp;
        logic [VW-1:0] tan;
        logic [VW-1:0] res;
        bit            fi;
        bit            fs;
        bit            last;
    } eq_word_t;

    typedef struct {
        logic [VW-1:0]            lf;
        logic [CTRL_EQ_WIDTH-1:0] ce;
        bit                       fault;
    } lf_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [VW-1:0] total_disp = '0;
    logic [VW-1:0] tangent_incr = '0;
    logic [VW-1:0] residual_incr = '0;
    logic first_iteration = 1'b0;
    logic first_step = 1'b0;
    logic last_equation = 1'b0;
    logic done;
    logic [VW-1:0] load_factor;
    logic [CTRL_EQ_WIDTH-1:0] control_equation;
    logic divide_fault;
    logic cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_VARIABLE_MODE;
    logic [VW-1:0] cfg_data = '0;

    displacement_control_load_factor uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .total_disp(total_disp), .tangent_incr(tangent_incr), .residual_incr(residual_incr),
        .first_iteration(first_iteration), .first_step(first_step),
        .last_equation(last_equation), .done(done), .load_factor(load_factor),
        .control_equation(control_equation), .divide_fault(divide_fault),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    eq_word_t   word_q[$];
    lf_result_t lf_expect_q[$];
    int errors = 0;
    int words_sent = 0;

    // predictor state
    logic [63:0] path_len[NEQ];
    logic [63:0] prev_disp[NEQ];
    bit          track_mode;
    int          eq_count;
    int          ctrl_eq;
    logic [63:0] ctrl_factor;
    int          eq_idx;
    int          peak_idx;
    logic [63:0] peak_abs;
    logic [63:0] ctrl_tan, ctrl_res, ctrl_len, peak_tan, peak_len;

    function automatic logic [63:0] sx(logic [VW-1:0] v);
        return {{(64-VW){v[VW-1]}}, v};
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] clamp_mag(bit neg, logic [63:0] m);
        if (neg)
            return (m > SIGN_BIT) ? NEG_MIN : -m;
        return (m > POS_MAX) ? POS_MAX : m;
    endfunction

    function automatic logic [63:0] q_negate(logic [63:0] v);
        return (v == NEG_MIN) ? POS_MAX : -v;
    endfunction

    function automatic logic [63:0] q_divide(logic [63:0] a, logic [63:0] b, inout bit flt);
        logic [127:0] num, quo;
        if (b == 0)
        begin
            flt = 1'b1;
            return a[63] ? NEG_MIN : POS_MAX;
        end
        num = {64'd0, magnitude(a)} << 24;
        quo = num / {64'd0, magnitude(b)};
        return clamp_mag(a[63] ^ b[63], (quo[127:64] != 0) ? '1 : quo[63:0]);
    endfunction

    function automatic logic [63:0] q_multiply(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return clamp_mag(a[63] ^ b[63], (p[127:88] != 0) ? '1 : p[87:24]);
    endfunction

    task automatic predict_word(eq_word_t w);
        logic [63:0] x, t, r, p, d, s, tm, lam, ratio;
        bit fl, tracking, same;
        int n, i;
        lf_result_t e;
        x = sx(w.disp);
        t = sx(w.tan);
        r = sx(w.res);
        fl = 1'b0;
        n = (eq_count == 0) ? 1 : eq_count;
        i = (eq_idx >= NEQ) ? NEQ - 1 : eq_idx;
        tracking = w.fi && !w.fs && track_mode;
        if (tracking)
        begin
            p = prev_disp[i];
            d = ($signed(x) >= $signed(p)) ? x - p : p - x;
            s = path_len[i] + d;
            if (s < d || s > POS_MAX)
                s = POS_MAX;
            path_len[i] = s;
            prev_disp[i] = x;
        end
        tm = magnitude(t);
        if (i == 0 || tm > peak_abs)
        begin
            peak_idx = i;
            peak_abs = tm;
            peak_tan = t;
            peak_len = path_len[i];
        end
        if (i == ctrl_eq)
        begin
            ctrl_tan = t;
            ctrl_res = r;
            ctrl_len = path_len[i];
        end
        if (!(w.last || i + 1 >= n || i + 1 >= NEQ))
        begin
            eq_idx = i + 1;
            return;
        end
        if (tracking && peak_idx != ctrl_eq)
        begin
            same = peak_tan != 0 && ctrl_tan != 0 && peak_tan[63] == ctrl_tan[63];
            ratio = q_divide(peak_len, ctrl_len, fl);
            if (!same)
                ratio = q_negate(ratio);
            ctrl_factor = q_multiply(ctrl_factor, ratio);
            ctrl_eq = peak_idx;
            ctrl_tan = peak_tan;
        end
        if (w.fi)
            lam = q_divide(ctrl_factor, ctrl_tan, fl);
        else
            lam = q_divide(q_negate(ctrl_res), ctrl_tan, fl);
        e.lf = lam[VW-1:0];
        e.ce = ctrl_eq[CTRL_EQ_WIDTH-1:0];
        e.fault = fl;
        lf_expect_q.push_back(e);
        {ctrl_tan, ctrl_res, ctrl_len, peak_tan, peak_len} = '0;
        eq_idx = 0;
        peak_idx = 0;
        peak_abs = 0;
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, field, got, want);
        errors++;
    endtask

    // driver: hold a word until accepted, then fetch the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        eq_word_t w;
        bit go;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                w.disp = total_disp;
                w.tan = tangent_incr;
                w.res = residual_incr;
                w.fi = first_iteration;
                w.fs = first_step;
                w.last = last_equation;
                predict_word(w);
                words_sent++;
                go = 1'b0;
            end
            if (!go && word_q.size() > 0 &&
                ((words_sent >= 700 && words_sent < 1000) || $urandom_range(99) >= 26))
            begin
                w = word_q.pop_front();
                total_disp <= w.disp;
                tangent_incr <= w.tan;
                residual_incr <= w.res;
                first_iteration <= w.fi;
                first_step <= w.fs;
                last_equation <= w.last;
                go = 1'b1;
            end
            start <= go;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lf_result_t e;
        if (rst_n && done)
        begin
            if (lf_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, load_factor);
                errors++;
            end
            else
            begin
                e = lf_expect_q.pop_front();
                if (load_factor !== e.lf)
                    report_mismatch("load_factor", 64'(load_factor), 64'(e.lf));
                if (control_equation !== e.ce)
                    report_mismatch("control_equation", 64'(control_equation), 64'(e.ce));
                if (divide_fault !== e.fault)
                    report_mismatch("divide_fault", 64'(divide_fault), 64'(e.fault));
            end
        end
    end

    function automatic logic [VW-1:0] rand_q();
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = POS_MAX;
            2: v = NEG_MIN;
            3: v = $urandom_range(1) ? 64'd1 : -64'd1;
            4, 5, 6: v = $urandom_range(1) ? 64'($urandom_range(1 << 28))
                                           : -64'($urandom_range(1 << 28));
            default: v = {$urandom, $urandom};
        endcase
        return v[VW-1:0];
    endfunction

    task automatic push_word(logic [63:0] d, logic [63:0] t, logic [63:0] r,
                             bit fi, bit fs, bit last);
        eq_word_t w;
        w.disp = d[VW-1:0];
        w.tan = t[VW-1:0];
        w.res = r[VW-1:0];
        w.fi = fi;
        w.fs = fs;
        w.last = last;
        word_q.push_back(w);
    endtask

    // one call of len words; a short call must end on last_equation
    task automatic push_call(int len, bit fi, bit fs, bit noisy);
        int n;
        bit wfi, wfs;
        n = (eq_count == 0) ? 1 : eq_count;
        for (int k = 0; k < len; k++)
        begin
            wfi = fi;
            wfs = fs;
            if (noisy || $urandom_range(19) == 0)
            begin
                wfi = $urandom_range(1);
                wfs = $urandom_range(1);
            end
            push_word(sx(rand_q()), sx(rand_q()), sx(rand_q()), wfi, wfs,
                      (k == len - 1) && (len < n || $urandom_range(1)));
        end
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[VW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VARIABLE_MODE:    track_mode = val[0];
            CFG_EQUATIONS_IN_USE: eq_count = int'(val[12:0]);
            CFG_INIT_CTRL_EQ:     ctrl_eq = int'(val[11:0]);
            default:              ctrl_factor = sx(val[VW-1:0]);
        endcase
    endtask

    // drain all words and results, then let the end computation finish
    task automatic settle();
        int guard;
        guard = 0;
        while ((word_q.size() != 0 || start || lf_expect_q.size() != 0) && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        if (lf_expect_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, lf_expect_q.size());
            errors++;
            lf_expect_q.delete();
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic run_phase(bit vm, int n, int ce, logic [63:0] fac, int budget);
        int len, steps;
        cfg_write(CFG_VARIABLE_MODE, 64'(vm));
        cfg_write(CFG_EQUATIONS_IN_USE, 64'(n));
        cfg_write(CFG_INIT_CTRL_EQ, 64'(ce));
        cfg_write(CFG_INIT_CTRL_FACTOR, fac);
        if (n == 0)
            n = 1;
        steps = 0;
        while (budget > 0)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(1, n) : n;
            if ($urandom_range(9) == 0)
                push_call(len, 1'b0, 1'b0, 1'b1);
            else if (steps == 0)
                push_call(len, $urandom_range(1), 1'b1, 1'b0);
            else
            begin
                push_call(len, 1'b1, 1'b0, 1'b0);
                budget -= len;
                for (int k = $urandom_range(3); k > 0; k--)
                begin
                    push_call(n, 1'b0, 1'b0, 1'b0);
                    budget -= n;
                end
            end
            budget -= len;
            steps++;
        end
        settle();
    endtask

    initial
    begin
        int n;
        foreach (path_len[k])
        begin
            path_len[k] = 0;
            prev_disp[k] = 0;
        end
        track_mode = 0;
        eq_count = NEQ;
        ctrl_eq = 0;
        ctrl_factor = ONE_Q;
        eq_idx = 0;
        peak_idx = 0;
        peak_abs = 0;
        {ctrl_tan, ctrl_res, ctrl_len, peak_tan, peak_len} = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        // wait out the RAM clearing pass
        while (busy)
            @(posedge clk);

        // reset configuration, calls cut short by last_equation
        push_word(0, POS_MAX, NEG_MIN, 1, 1, 1);
        push_word(POS_MAX, NEG_MIN, POS_MAX, 0, 1, 1);
        push_word(NEG_MIN, 0, 1, 1, 0, 1);
        push_word(1, -64'd1, NEG_MIN, 0, 0, 1);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(0, 64'd5 << 24, 64'd3 << 24, 0, 0, 1);
        settle();
        // tracking: first step, then a step where equation 1 takes over
        cfg_write(CFG_VARIABLE_MODE, 1);
        cfg_write(CFG_EQUATIONS_IN_USE, 2);
        cfg_write(CFG_INIT_CTRL_EQ, 0);
        cfg_write(CFG_INIT_CTRL_FACTOR, ONE_Q);
        push_word(64'd1 << 24, 64'd1 << 24, 0, 1, 1, 0);
        push_word(64'd2 << 24, 64'd1 << 22, 0, 1, 1, 1);
        push_word(64'd3 << 24, 64'd1 << 23, 64'd1 << 20, 1, 0, 0);
        push_word(-64'd4 << 24, -64'd9 << 24, 64'd1 << 20, 1, 0, 0);
        push_word(64'd3 << 24, 64'd1 << 20, 64'd7 << 20, 0, 0, 0);
        push_word(-64'd4 << 24, -64'd8 << 24, NEG_MIN, 0, 0, 0);
        push_word(64'd5 << 24, 64'd9 << 24, 0, 1, 0, 0);
        push_word(-64'd6 << 24, -64'd1 << 24, 0, 1, 0, 0);
        settle();
        // control equation never streamed; zero count acts as one
        cfg_write(CFG_INIT_CTRL_EQ, 3);
        push_word(1, 64'd1 << 24, 1, 0, 0, 0);
        push_word(1, 64'd1 << 24, 1, 0, 0, 1);
        settle();
        cfg_write(CFG_EQUATIONS_IN_USE, 0);
        cfg_write(CFG_INIT_CTRL_EQ, 0);
        cfg_write(CFG_INIT_CTRL_FACTOR, NEG_MIN);
        push_word(POS_MAX, 64'd1, 0, 1, 0, 0);
        push_word(NEG_MIN, -64'd1, POS_MAX, 0, 0, 0);
        settle();

        // one call, usually full length, with the highest control equation
        run_phase(1'b1, NEQ, NEQ - 1, POS_MAX, 1);

        while (words_sent < 1800 + NEQ)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: n = $urandom_range(1, 4);
                4, 5, 6, 7: n = $urandom_range(5, 16);
                default:    n = $urandom_range(17, 64);
            endcase
            run_phase($urandom_range(3) != 0, n,
                      ($urandom_range(7) == 0) ? $urandom_range(n, NEQ - 1)
                                               : $urandom_range(n - 1),
                      ($urandom_range(3) == 0) ? sx(rand_q())
                                               : 64'($urandom_range(1 << 26)),
                      150);
        end
        settle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #9ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
